FILE: rtl/spq_pkg.sv
// shared constants, codes and controller/datapath link types for the sorted priority queue
// no dependencies

package spq_pkg;

    localparam int DEPTH         = 16;
    localparam int PRIO_BITS     = 8;
    localparam int ITEM_BITS     = 32;
    localparam int CAP_BITS      = 5;
    localparam int COUNT_BITS    = 5;
    localparam int OCC_BITS      = $clog2(DEPTH + 1);
    localparam int CMP_BITS      = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;
    localparam int STATUS_BITS   = 2;
    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the incoming request
        logic exec;   // apply the captured request and fill the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_valid;
    } t_stat;

endpackage

FILE: rtl/spq_ctrl.sv
// controller for the sorted priority queue: request intake and execute sequencing
// depends on spq_pkg

module spq_ctrl import spq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // wait while an earlier result still sits unclaimed
                if (!i_stat.out_valid || !i_out_stall) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/spq_dp.sv
// datapath for the sorted priority queue: shift-register sorted array, occupancy,
// capacity register and result register; depends on spq_pkg

module spq_dp import spq_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    output t_stat                       o_stat,
    input  logic                        i_op,
    input  logic signed [ITEM_BITS-1:0] i_item_value,
    input  logic [PRIO_BITS-1:0]        i_priority_req,
    input  logic                        i_cfg_we,
    input  logic [CAP_BITS-1:0]         i_cfg_data,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [STATUS_BITS-1:0]      o_status,
    output logic signed [ITEM_BITS-1:0] o_removed_item,
    output logic [COUNT_BITS-1:0]       o_entry_count
);

    logic [ITEM_BITS-1:0]   r_items [DEPTH];
    logic [PRIO_BITS-1:0]   r_prios [DEPTH];
    logic [ITEM_BITS-1:0]   n_items [DEPTH];
    logic [PRIO_BITS-1:0]   n_prios [DEPTH];
    logic [OCC_BITS-1:0]    r_occ;
    logic [OCC_BITS-1:0]    n_occ;
    logic [CAP_BITS-1:0]    r_capacity;

    logic                   r_op;
    logic [ITEM_BITS-1:0]   r_item;
    logic [PRIO_BITS-1:0]   r_prio;

    logic                   r_out_valid;
    logic [STATUS_BITS-1:0] r_status;
    logic [ITEM_BITS-1:0]   r_removed;
    logic [COUNT_BITS-1:0]  r_count;

    logic [STATUS_BITS-1:0] n_status;
    logic [ITEM_BITS-1:0]   n_removed;
    logic [DEPTH-1:0]       lt;
    logic                   full;
    logic                   empty;

    // per-slot compare: slot holds a live entry with strictly smaller priority
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            lt[k] = (CMP_BITS'(k) < CMP_BITS'(r_occ)) && (r_prios[k] < r_prio);
        end
    end

    assign full  = (CMP_BITS'(r_occ) >= CMP_BITS'(r_capacity)) ||
                   (CMP_BITS'(r_occ) >= CMP_BITS'(DEPTH));
    assign empty = (r_occ == '0);

    always_comb begin
        n_items   = r_items;
        n_prios   = r_prios;
        n_occ     = r_occ;
        n_status  = ST_OK;
        n_removed = '0;
        if (r_op == OP_ENQUEUE) begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                // sorted array: lt is a thermometer, the first clear slot takes the new entry
                for (int k = 0; k < DEPTH; k++) begin
                    if (!lt[k]) begin
                        if (k == 0) begin
                            n_items[k] = r_item;
                            n_prios[k] = r_prio;
                        end else if (lt[k-1]) begin
                            n_items[k] = r_item;
                            n_prios[k] = r_prio;
                        end else begin
                            n_items[k] = r_items[k-1];
                            n_prios[k] = r_prios[k-1];
                        end
                    end
                end
                n_occ = r_occ + OCC_BITS'(1);
            end
        end else begin
            if (empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_removed = r_items[0];
                for (int k = 0; k < DEPTH - 1; k++) begin
                    n_items[k] = r_items[k+1];
                    n_prios[k] = r_prios[k+1];
                end
                n_occ = r_occ - OCC_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                r_occ       <= n_occ;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_item <= i_item_value;
            r_prio <= i_priority_req;
        end
        if (i_cmd.exec) begin
            r_items   <= n_items;
            r_prios   <= n_prios;
            r_status  <= n_status;
            r_removed <= n_removed;
            r_count   <= COUNT_BITS'(n_occ);
        end
    end

    assign o_stat.out_valid = r_out_valid;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_removed_item   = r_removed;
    assign o_entry_count    = r_count;

endmodule

FILE: rtl/sorted_priority_queue.sv
// top level of the sorted priority queue: controller plus datapath
// depends on spq_pkg, spq_ctrl, spq_dp
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------------
//  input    | i_in_valid / o_in_stall | i_op, i_item_value, i_priority_req
//  output   | o_out_valid/ i_out_stall| o_status, o_removed_item, o_entry_count
//  config   | i_cfg_we                | i_cfg_data (capacity)
//
// each request is captured in S_IDLE, then applied in S_EXEC by the parallel compare
// and shift of all sixteen slots of the sorted array
// a new request is taken while the previous result waits in the output register
// a stalled output holds the execute step, and with it the next request
// synchronous active-low reset empties the queue and sets capacity to 16

module sorted_priority_queue import spq_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_op,
    input  logic signed [ITEM_BITS-1:0] i_item_value,
    input  logic [PRIO_BITS-1:0]        i_priority_req,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [STATUS_BITS-1:0]      o_status,
    output logic signed [ITEM_BITS-1:0] o_removed_item,
    output logic [COUNT_BITS-1:0]       o_entry_count,
    input  logic                        i_cfg_we,
    input  logic [CAP_BITS-1:0]         i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    spq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_op           (i_op),
        .i_item_value   (i_item_value),
        .i_priority_req (i_priority_req),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_removed_item (o_removed_item),
        .o_entry_count  (o_entry_count)
    );

endmodule

FILE: rtl/spq_checker.sv
// port-level checks for the sorted priority queue, bound to the top level
// depends on spq_pkg and sorted_priority_queue

module spq_checker import spq_pkg::*; (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [STATUS_BITS-1:0]      o_status,
    input logic signed [ITEM_BITS-1:0] o_removed_item,
    input logic [COUNT_BITS-1:0]       o_entry_count
);

    // one request in flight: an accepted request blocks the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while previous one still executing");

    // only a successful dequeue returns an item
    a_no_item_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_removed_item == '0))
        else $error("nonzero item on failed request");

    // empty report only when nothing is stored
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EMPTY) |-> (o_entry_count == '0))
        else $error("empty reported with entries stored");

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_removed_item) &&
             $stable(o_entry_count)))
        else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_removed_item (o_removed_item),
    .o_entry_count  (o_entry_count)
);

FILE: dv/tb_sorted_priority_queue.sv
// self-checking testbench for sorted_priority_queue: random enqueue/dequeue traffic with
// random input gaps and output stalls, checked against a behavioral queue in a scoreboard class
// depends on spq_pkg and the sorted_priority_queue rtl
`timescale 1ns / 100ps

module tb_sorted_priority_queue;
    import spq_pkg::*;

    typedef struct {
        logic [STATUS_BITS-1:0]      status;
        logic signed [ITEM_BITS-1:0] removed;
        logic [COUNT_BITS-1:0]       count;
    } t_queue_result;

    // behavioral sorted array plus the results it still owes
    class t_priority_queue_tracker;
        logic signed [ITEM_BITS-1:0] slot_item [DEPTH];
        logic [PRIO_BITS-1:0]        slot_prio [DEPTH];
        int unsigned                 fill;
        logic [CAP_BITS-1:0]         capacity;
        t_queue_result               pending_results [$];
        int unsigned                 errors;

        function new();
            fill     = 0;
            capacity = CAP_RESET;
            errors   = 0;
        endfunction

        function void set_capacity(logic [CAP_BITS-1:0] cap);
            capacity = cap;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void note_request(logic op, logic signed [ITEM_BITS-1:0] item,
                                   logic [PRIO_BITS-1:0] prio);
            t_queue_result want;
            int unsigned   limit;
            int unsigned   loc;
            want.status  = ST_OK;
            want.removed = '0;
            limit = (capacity > DEPTH) ? DEPTH : capacity;
            if (op == OP_ENQUEUE) begin
                if (fill >= limit) begin
                    want.status = ST_FULL;
                end else begin
                    // ties go in front of older entries of the same priority
                    loc = 0;
                    while (loc < fill && slot_prio[loc] < prio) loc++;
                    for (int i = fill; i > loc; i--) begin
                        slot_item[i] = slot_item[i-1];
                        slot_prio[i] = slot_prio[i-1];
                    end
                    slot_item[loc] = item;
                    slot_prio[loc] = prio;
                    fill++;
                end
            end else begin
                if (fill == 0) begin
                    want.status = ST_EMPTY;
                end else begin
                    want.removed = slot_item[0];
                    for (int i = 1; i < fill; i++) begin
                        slot_item[i-1] = slot_item[i];
                        slot_prio[i-1] = slot_prio[i];
                    end
                    fill--;
                end
            end
            want.count = COUNT_BITS'(fill);
            pending_results.push_back(want);
        endfunction

        function void check_result(logic [STATUS_BITS-1:0] status,
                                   logic signed [ITEM_BITS-1:0] removed,
                                   logic [COUNT_BITS-1:0] count);
            t_queue_result want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d removed_item %0d entry_count %0d",
                       status, removed, count);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d actual %0d", want.status, status);
                errors++;
            end
            if (removed !== want.removed) begin
                $error("removed_item: expected %0d actual %0d", want.removed, removed);
                errors++;
            end
            if (count !== want.count) begin
                $error("entry_count: expected %0d actual %0d", want.count, count);
                errors++;
            end
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic                        i_op = OP_ENQUEUE;
    logic signed [ITEM_BITS-1:0] i_item_value = '0;
    logic [PRIO_BITS-1:0]        i_priority_req = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [STATUS_BITS-1:0]      o_status;
    logic signed [ITEM_BITS-1:0] o_removed_item;
    logic [COUNT_BITS-1:0]       o_entry_count;
    logic                        i_cfg_we = 1'b0;
    logic [CAP_BITS-1:0]         i_cfg_data = '0;

    t_priority_queue_tracker queue_track = new();
    bit                      in_quiet = 1'b0;
    bit                      out_quiet = 1'b0;
    int unsigned             out_hold = 0;

    sorted_priority_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_item_value   (i_item_value),
        .i_priority_req (i_priority_req),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_removed_item (o_removed_item),
        .o_entry_count  (o_entry_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    // result side: check each accepted result, then hold stall for a random count
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            queue_track.check_result(o_status, o_removed_item, o_entry_count);
            out_hold = draw_wait(out_quiet);
        end else if (out_hold != 0) begin
            out_hold--;
        end
        i_out_stall <= (out_hold != 0);
    end

    task automatic send_request(input logic op, input logic signed [ITEM_BITS-1:0] item,
                                input logic [PRIO_BITS-1:0] prio);
        int unsigned gap;
        gap = draw_wait(in_quiet);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_item_value   <= item;
        i_priority_req <= prio;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        queue_track.note_request(op, item, prio);
    endtask

    // capacity changes only once every request has drained
    task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
        i_in_valid <= 1'b0;
        while (queue_track.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        queue_track.set_capacity(cap);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_traffic(input int unsigned n, input int unsigned enq_pct,
                                  input bit narrow);
        logic                        op;
        logic signed [ITEM_BITS-1:0] item;
        logic [PRIO_BITS-1:0]        prio;
        for (int k = 0; k < n; k++) begin
            op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
            case ($urandom_range(0, 7))
                0: item = 32'sh8000_0000;
                1: item = 32'sh7fff_ffff;
                default: item = $urandom();
            endcase
            // narrow mode crowds priorities at both ends to force ties
            if (narrow) begin
                prio = PRIO_BITS'($urandom_range(0, 3));
                if ($urandom_range(0, 1) != 0) prio = prio | 8'hfc;
            end else begin
                prio = PRIO_BITS'($urandom());
            end
            send_request(op, item, prio);
        end
    endtask

    initial begin
        logic [CAP_BITS-1:0] caps [9];
        caps = '{5'd31, 5'd1, 5'd16, 5'd0, 5'd8, 5'd2, 5'd17, 5'd15, 5'd12};
        caps[5] = CAP_BITS'($urandom_range(0, 31));
        caps[8] = CAP_BITS'($urandom_range(0, 31));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty, extremes, ties at the low end and mid-range
        send_request(OP_DEQUEUE, 32'sh1234_5678, 8'd9);
        send_request(OP_ENQUEUE, 32'sh7fff_ffff, 8'd255);
        send_request(OP_ENQUEUE, 32'sh8000_0000, 8'd0);
        send_request(OP_ENQUEUE, -32'sd1, 8'd128);
        send_request(OP_ENQUEUE, 32'sd0, 8'd128);
        send_request(OP_ENQUEUE, 32'sh5555_5555, 8'd0);
        send_request(OP_DEQUEUE, 32'shffff_ffff, 8'hff);
        send_request(OP_DEQUEUE, 32'sd0, 8'd0);

        // capacity lowered below the stored count
        write_capacity(5'd2);
        send_request(OP_ENQUEUE, 32'sh0f0f_0f0f, 8'd7);
        send_request(OP_DEQUEUE, 32'sd0, 8'd0);
        send_request(OP_DEQUEUE, 32'sd0, 8'd0);
        send_request(OP_ENQUEUE, 32'shaaaa_aaaa, 8'd1);
        send_request(OP_ENQUEUE, 32'sh3333_3333, 8'd1);

        // capacity zero: enqueues refused, dequeues still drain
        write_capacity(5'd0);
        send_request(OP_ENQUEUE, 32'sh0000_0001, 8'd1);
        send_request(OP_DEQUEUE, 32'sd0, 8'd0);
        send_request(OP_DEQUEUE, 32'sd0, 8'd0);
        send_request(OP_DEQUEUE, 32'sd0, 8'd0);

        for (int p = 0; p < 9; p++) begin
            write_capacity(caps[p]);
            in_quiet  = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);
            random_traffic(150, (p % 3 == 0) ? 65 : ((p % 3 == 1) ? 35 : 50), p[0]);
        end

        i_in_valid <= 1'b0;
        while (queue_track.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (queue_track.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
